// ===== rtl/core/afwp_pkg.sv =====
// afwp_pkg: shared types, codes and constants of the animation frame word parser.
// No dependencies; used by every module under rtl/core.
`timescale 1ns / 1ps

package afwp_pkg;

  // Result queue depth default (must be at least 2)
  localparam int FIFO_DEPTH = 4;

  // Register map (word index = paddr[3:2])
  localparam int          ADDR_W          = 4;
  localparam logic [1:0]  REG_FORMAT_MODE = 2'd0;
  localparam logic [1:0]  REG_MESHES      = 2'd1;
  localparam logic [1:0]  REG_FRAME_WORDS = 2'd2;

  // Reset values of the registers
  localparam logic [1:0]  FORMAT_MODE_RST = 2'd1;
  localparam logic [7:0]  MESHES_RST      = 8'd0;
  localparam logic [7:0]  FRAME_WORDS_RST = 8'd0;

  // Format modes
  localparam logic [1:0]  MODE_GEN1   = 2'd0;
  localparam logic [1:0]  MODE_TEN    = 2'd1;
  localparam logic [1:0]  MODE_TWELVE = 2'd2;
  localparam logic [1:0]  MODE_RSVD   = 2'd3;

  // Pack mode in the top two bits of a rotation word
  localparam logic [1:0]  PACK_ALL = 2'd0;
  localparam logic [1:0]  PACK_X   = 2'd1;
  localparam logic [1:0]  PACK_Y   = 2'd2;
  localparam logic [1:0]  PACK_Z   = 2'd3;

  // Result kinds
  localparam logic [1:0]  KIND_HEADER = 2'd0;
  localparam logic [1:0]  KIND_ROT    = 2'd1;
  localparam logic [1:0]  KIND_END    = 2'd2;

  // Parser phases
  localparam logic [2:0]  PH_HEADER = 3'd0;
  localparam logic [2:0]  PH_COUNT  = 3'd1;
  localparam logic [2:0]  PH_ROT    = 3'd2;
  localparam logic [2:0]  PH_ROT2   = 3'd3;
  localparam logic [2:0]  PH_PAD    = 3'd4;

  localparam logic [3:0]  HEADER_WORDS = 4'd9;
  localparam logic [15:0] WORDS_MAX    = 16'hFFFF;

  typedef struct packed {
    logic [1:0] format_mode;
    logic [7:0] meshes_per_frame;
    logic [7:0] frame_words;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  index;
    logic [15:0] rot_x;
    logic [15:0] rot_y;
    logic [15:0] rot_z;
    logic        last;
  } result_t;

endpackage

// ===== rtl/core/afwp_regs.sv =====
// afwp_regs: APB-style configuration registers of the frame word parser.
// Depends on afwp_pkg (register map, reset values, cfg_t).
`timescale 1ns / 1ps

module afwp_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [afwp_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output afwp_pkg::cfg_t              cfg
);

  logic       wr_en;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];
  assign wr_en   = psel & penable & pwrite;

  // Register writes; unmapped addresses are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.format_mode      <= afwp_pkg::FORMAT_MODE_RST;
      cfg.meshes_per_frame <= afwp_pkg::MESHES_RST;
      cfg.frame_words      <= afwp_pkg::FRAME_WORDS_RST;
    end else if (wr_en) begin
      case (reg_sel)
        afwp_pkg::REG_FORMAT_MODE: cfg.format_mode      <= pwdata[1:0];
        afwp_pkg::REG_MESHES:      cfg.meshes_per_frame <= pwdata[7:0];
        afwp_pkg::REG_FRAME_WORDS: cfg.frame_words      <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_sel)
      afwp_pkg::REG_FORMAT_MODE: prdata = {30'd0, cfg.format_mode};
      afwp_pkg::REG_MESHES:      prdata = {24'd0, cfg.meshes_per_frame};
      afwp_pkg::REG_FRAME_WORDS: prdata = {24'd0, cfg.frame_words};
      default:                   prdata = 32'd0;
    endcase
  end

endmodule

// ===== rtl/core/afwp_decode.sv =====
// afwp_decode: frame parse state and the single-pass decode of one word into
// up to two results. Depends on afwp_pkg (phases, codes, cfg_t, result_t).
`timescale 1ns / 1ps

module afwp_decode (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic [15:0]        word,
  input  logic               restart,
  input  afwp_pkg::cfg_t     cfg,
  output afwp_pkg::result_t  res0,
  output afwp_pkg::result_t  res1,
  output logic [1:0]         res_n
);

  // Parse state
  logic [2:0]  phase,      phase_next;
  logic [3:0]  header_pos, header_pos_next;
  logic [7:0]  mesh_pos,   mesh_pos_next;
  logic [7:0]  mesh_total, mesh_total_next;
  logic [15:0] held_word,  held_word_next;
  logic [15:0] words_used, words_used_next;

  // Starting point after an optional restart
  logic [2:0]  ph0;
  logic [3:0]  hp0;
  logic [7:0]  mp0, mt0;
  logic [15:0] hw0, wu0;

  logic [1:0]  mode;
  logic [7:0]  count_val;
  logic [15:0] axis_val;
  logic [15:0] ax_a, ax_b;
  logic [3:0]  hp1;
  logic [7:0]  mp1;
  logic        have_item, do_rot, meshes_done, end_now;
  logic [15:0] rx, ry, rz;
  afwp_pkg::result_t item, end_item;

  // Mode three decodes as mode two
  assign mode = (cfg.format_mode == afwp_pkg::MODE_RSVD) ? afwp_pkg::MODE_TWELVE
                                                          : cfg.format_mode;

  // Signed count word: negative -> 0, above 255 -> 255
  assign count_val = word[15] ? 8'd0 : ((|word[14:8]) ? 8'hFF : word[7:0]);

  // Single-axis value: ten-bit field shifted by 6, or twelve-bit shifted by 4
  assign axis_val = (mode == afwp_pkg::MODE_TEN) ? {word[9:0], 6'd0} : {word[11:0], 4'd0};

  always_comb begin
    if (restart) begin
      ph0 = afwp_pkg::PH_HEADER;
      hp0 = 4'd0;
      mp0 = 8'd0;
      mt0 = 8'd0;
      hw0 = 16'd0;
      wu0 = 16'd0;
    end else begin
      ph0 = phase;
      hp0 = header_pos;
      mp0 = mesh_pos;
      mt0 = mesh_total;
      hw0 = held_word;
      wu0 = words_used;
    end

    phase_next      = ph0;
    header_pos_next = hp0;
    mesh_pos_next   = mp0;
    mesh_total_next = mt0;
    held_word_next  = hw0;
    words_used_next = (wu0 != afwp_pkg::WORDS_MAX) ? wu0 + 16'd1 : wu0;

    have_item   = 1'b0;
    item        = '0;
    do_rot      = 1'b0;
    meshes_done = 1'b0;
    end_now     = 1'b0;
    rx          = 16'd0;
    ry          = 16'd0;
    rz          = 16'd0;
    hp1         = hp0 + 4'd1;
    mp1         = mp0 + 8'd1;
    ax_a        = 16'd0;
    ax_b        = 16'd0;

    case (ph0)
      afwp_pkg::PH_HEADER: begin
        have_item  = 1'b1;
        item.kind  = afwp_pkg::KIND_HEADER;
        item.index = {4'd0, hp0};
        item.rot_x = word;
        if (hp1 >= afwp_pkg::HEADER_WORDS) begin
          header_pos_next = 4'd0;
          mesh_pos_next   = 8'd0;
          if (mode == afwp_pkg::MODE_GEN1) begin
            phase_next = afwp_pkg::PH_COUNT;
          end else begin
            mesh_total_next = cfg.meshes_per_frame;
            if (cfg.meshes_per_frame == 8'd0) meshes_done = 1'b1;
            else phase_next = afwp_pkg::PH_ROT;
          end
        end else begin
          header_pos_next = hp1;
        end
      end
      afwp_pkg::PH_COUNT: begin
        mesh_total_next = count_val;
        mesh_pos_next   = 8'd0;
        if (count_val == 8'd0) meshes_done = 1'b1;
        else phase_next = afwp_pkg::PH_ROT;
      end
      afwp_pkg::PH_ROT: begin
        if (mode == afwp_pkg::MODE_GEN1 || word[15:14] == afwp_pkg::PACK_ALL) begin
          held_word_next = word;
          phase_next     = afwp_pkg::PH_ROT2;
        end else begin
          do_rot = 1'b1;
          if (word[15:14] == afwp_pkg::PACK_X) rx = axis_val;
          if (word[15:14] == afwp_pkg::PACK_Y) ry = axis_val;
          if (word[15:14] == afwp_pkg::PACK_Z) rz = axis_val;
        end
      end
      afwp_pkg::PH_ROT2: begin
        // Mode 0 stores the two words swapped
        do_rot = 1'b1;
        if (mode == afwp_pkg::MODE_GEN1) begin
          ax_a = word;
          ax_b = hw0;
        end else begin
          ax_a = hw0;
          ax_b = word;
        end
        rx = {ax_a[13:4], 6'd0};
        ry = {ax_a[3:0], ax_b[15:10], 6'd0};
        rz = {ax_b[9:0], 6'd0};
      end
      default: begin
        // Padding: skip until the frame has its minimum length
        if (words_used_next >= {8'd0, cfg.frame_words}) end_now = 1'b1;
      end
    endcase

    // Rotation result and mesh count
    if (do_rot) begin
      have_item     = 1'b1;
      item.kind     = afwp_pkg::KIND_ROT;
      item.index    = mp0;
      item.rot_x    = rx;
      item.rot_y    = ry;
      item.rot_z    = rz;
      mesh_pos_next = mp1;
      if (mp1 >= mt0) meshes_done = 1'b1;
      else phase_next = afwp_pkg::PH_ROT;
    end

    // All meshes done: pad in the later modes while short of frame_words, else end the frame
    if (meshes_done) begin
      if (mode != afwp_pkg::MODE_GEN1 && words_used_next < {8'd0, cfg.frame_words})
        phase_next = afwp_pkg::PH_PAD;
      else
        end_now = 1'b1;
    end

    end_item       = '0;
    end_item.kind  = afwp_pkg::KIND_END;
    end_item.index = mesh_total_next;

    if (end_now) begin
      phase_next      = afwp_pkg::PH_HEADER;
      header_pos_next = 4'd0;
      mesh_pos_next   = 8'd0;
      mesh_total_next = 8'd0;
      held_word_next  = 16'd0;
      words_used_next = 16'd0;
    end
  end

  // Pack results in order; last marks the final one of this word
  always_comb begin
    res0      = have_item ? item : end_item;
    res0.last = ~(have_item & end_now);
    res1      = end_item;
    res1.last = 1'b1;
    res_n     = {1'b0, have_item} + {1'b0, end_now};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= afwp_pkg::PH_HEADER;
      header_pos <= 4'd0;
      mesh_pos   <= 8'd0;
      mesh_total <= 8'd0;
      held_word  <= 16'd0;
      words_used <= 16'd0;
    end else if (en) begin
      phase      <= phase_next;
      header_pos <= header_pos_next;
      mesh_pos   <= mesh_pos_next;
      mesh_total <= mesh_total_next;
      held_word  <= held_word_next;
      words_used <= words_used_next;
    end
  end

endmodule

// ===== rtl/core/afwp_fifo.sv =====
// afwp_fifo: result queue that takes zero to two results per cycle and
// delivers one per transfer. Depends on afwp_pkg (result_t).
`timescale 1ns / 1ps

module afwp_fifo #(
  parameter int DEPTH = afwp_pkg::FIFO_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [1:0]         wr_n,
  input  afwp_pkg::result_t  wr_data0,
  input  afwp_pkg::result_t  wr_data1,
  input  logic               pop,
  output afwp_pkg::result_t  head,
  output logic               not_empty,
  output logic               room
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  afwp_pkg::result_t mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr, wr_ptr_inc, wr_ptr_inc2, rd_ptr_inc;
  logic [CW-1:0] count;
  logic          do_pop;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign wr_ptr_inc  = ptr_inc(wr_ptr);
  assign wr_ptr_inc2 = ptr_inc(wr_ptr_inc);
  assign rd_ptr_inc  = ptr_inc(rd_ptr);
  assign not_empty   = (count != '0);
  assign do_pop      = pop & not_empty;
  assign head        = mem[rd_ptr];
  // Two free slots are needed before the next word is decoded
  assign room        = (count <= CW'(DEPTH - 2));

  // Storage
  always_ff @(posedge clk) begin
    if (wr_n != 2'd0) mem[wr_ptr] <= wr_data0;
    if (wr_n == 2'd2) mem[wr_ptr_inc] <= wr_data1;
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      case (wr_n)
        2'd1:    wr_ptr <= wr_ptr_inc;
        2'd2:    wr_ptr <= wr_ptr_inc2;
        default: ;
      endcase
      if (do_pop) rd_ptr <= rd_ptr_inc;
      count <= count + CW'(wr_n) - CW'(do_pop);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("result queue overflow");

  a_push_only: assert property (@(posedge clk) disable iff (rst)
    (wr_n != 2'd0 && !do_pop) |=> count == $past(count) + CW'($past(wr_n)))
    else $error("fill level wrong after push");

  a_pop_only: assert property (@(posedge clk) disable iff (rst)
    (wr_n == 2'd0 && do_pop) |=> count == $past(count) - CW'(1))
    else $error("fill level wrong after pop");

  a_push_needs_room: assert property (@(posedge clk) disable iff (rst)
    (wr_n != 2'd0) |-> (count + CW'(wr_n) <= CW'(DEPTH)))
    else $error("push without room");
`endif

endmodule

// ===== rtl/core/anim_frame_word_parser_unit.sv =====
// anim_frame_word_parser_unit: top level of the animation frame word parser.
// Depends on afwp_pkg, afwp_regs, afwp_decode and afwp_fifo.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid, in_stall, word, restart) carries one 16-bit frame
//   word per transfer; restart marks the first word of a new frame and drops
//   any unfinished frame. Output channel (out_valid, out_stall, kind, index,
//   rot_x, rot_y, rot_z, last) carries results: header words, mesh rotations
//   and one frame end per frame; last flags the final result of a word.
//   The APB port (psel, penable, pwrite, paddr, pwdata, prdata, pready) holds
//   format_mode at 0x0, meshes_per_frame at 0x4, frame_words at 0x8; write
//   it only while the parser is idle.
//   Path: a word is held in the input register, is decoded into the result
//   queue once the queue has two free slots, and its first result can then
//   transfer from the queue.
//   Throughput: one word per cycle while each word gives at most one result
//   and out_stall stays low; words that give two results leave one result per
//   transfer through the single read port of the result queue.
//   Reset: synchronous; the parser waits for header word 0, registers take
//   their reset values (format_mode 1) and the queue empties.
//   Output stall: results back up in the queue (FIFO_DEPTH entries); once
//   fewer than two slots are free a held input word waits and in_stall rises.

module anim_frame_word_parser_unit #(
  parameter int FIFO_DEPTH = afwp_pkg::FIFO_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [afwp_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  // input words
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [15:0]                 word,
  input  logic                        restart,
  // results
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  kind,
  output logic [7:0]                  index,
  output logic [15:0]                 rot_x,
  output logic [15:0]                 rot_y,
  output logic [15:0]                 rot_z,
  output logic                        last
);

  afwp_pkg::cfg_t    cfg;
  afwp_pkg::result_t res0, res1, head;
  logic [1:0]        res_n;
  logic              room, advance;

  // Input register
  logic        in_full;
  logic [15:0] in_word;
  logic        in_restart;

  assign advance  = in_full & room;
  assign in_stall = in_full & ~room;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_word    <= word;
      in_restart <= restart;
    end
  end

  afwp_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  afwp_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .en      (advance),
    .word    (in_word),
    .restart (in_restart),
    .cfg     (cfg),
    .res0    (res0),
    .res1    (res1),
    .res_n   (res_n)
  );

  afwp_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .wr_n      (advance ? res_n : 2'd0),
    .wr_data0  (res0),
    .wr_data1  (res1),
    .pop       (~out_stall),
    .head      (head),
    .not_empty (out_valid),
    .room      (room)
  );

  // Result fields from the queue head
  assign kind  = head.kind;
  assign index = head.index;
  assign rot_x = head.rot_x;
  assign rot_y = head.rot_y;
  assign rot_z = head.rot_z;
  assign last  = head.last;

endmodule
